FILE: sv/b2d_pkg.sv
package b2d_pkg;

   // ascii code of the digit zero, six bits wide like the result field
   localparam logic [5:0] ASCII_ZERO = 6'd48;

   // smallest digit that needs the +3 correction before a shift
   localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
   localparam logic [3:0] BCD_ADJ_ADD   = 4'd3;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_CONVERT,
      BACK_EMIT
   } back_state_type;

endpackage

FILE: sv/b2d_front.sv
module b2d_front #(
   parameter int VALUE_BITS = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [63:0]           req_value_high,
   input  logic [63:0]           req_value_low,
   output logic                  q_valid,
   input  logic                  q_pop,
   output logic [VALUE_BITS-1:0] q_value,
   output logic                  q_zero
);
   import b2d_pkg::*;

   localparam int DEPTH = 2;

   logic [127:0]           full_value;
   logic [VALUE_BITS-1:0]  masked_value;
   logic                   push;

   logic [VALUE_BITS-1:0]  value_ff [DEPTH];
   logic                   zero_ff  [DEPTH];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;

   // bits above VALUE_BITS are dropped here
   assign full_value   = {req_value_high, req_value_low};
   assign masked_value = full_value[VALUE_BITS-1:0];

   assign req_ready = (count_ff != 2'(DEPTH));
   assign push      = req_valid && req_ready;

   assign q_valid = (count_ff != 2'd0);
   assign q_value = value_ff[rd_ptr_ff];
   assign q_zero  = zero_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         value_ff[wr_ptr_ff] <= masked_value;
         zero_ff[wr_ptr_ff]  <= (masked_value == '0);
      end
   end

endmodule

FILE: sv/b2d_back.sv
module b2d_back #(
   parameter int VALUE_BITS = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  logic [VALUE_BITS-1:0] q_value,
   input  logic                  q_zero,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [5:0]            rsp_char_code,
   output logic                  rsp_last_digit
);
   import b2d_pkg::*;

   // decimal digits of 2**VALUE_BITS - 1, log10(2) ~ 0.30103
   localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BCD_W      = NUM_DIGITS * 4;
   localparam int CNT_W      = $clog2(VALUE_BITS + 1);

   back_state_type         state_ff, state_in;
   logic [VALUE_BITS-1:0]  bin_ff, bin_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   started_ff, started_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [5:0]             rsp_char_code_ff, rsp_char_code_in;
   logic                   rsp_last_digit_ff, rsp_last_digit_in;

   logic [3:0]             top_digit;
   logic                   is_last;
   logic                   slot_free;
   logic                   skip;
   logic                   emit;

   assign top_digit = bcd_ff[BCD_W-1 -: 4];
   assign is_last   = (cnt_ff == CNT_W'(1));
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // add-3 correction on every digit, all digits side by side
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= BCD_ADJ_LIMIT) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + BCD_ADJ_ADD;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (q_valid) begin
               state_in = q_zero ? BACK_EMIT : BACK_CONVERT;
            end
         end
         BACK_CONVERT: begin
            if (is_last) begin
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (emit && is_last) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop = 1'b0;
      skip  = 1'b0;
      emit  = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            q_pop = q_valid;
         end
         BACK_CONVERT: begin
         end
         BACK_EMIT: begin
            // leading zeros are shifted out without a result
            if (top_digit == 4'd0 && !started_ff && !is_last) begin
               skip = 1'b1;
            end else if (slot_free) begin
               emit = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      bin_in            = bin_ff;
      bcd_in            = bcd_ff;
      cnt_in            = cnt_ff;
      started_in        = started_ff;
      rsp_char_code_in  = rsp_char_code_ff;
      rsp_last_digit_in = rsp_last_digit_ff;
      rsp_valid_in      = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (q_pop) begin
         bin_in     = q_value;
         bcd_in     = '0;
         cnt_in     = q_zero ? CNT_W'(1) : CNT_W'(VALUE_BITS);
         started_in = 1'b0;
      end

      if (state_ff == BACK_CONVERT) begin
         bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_BITS-1]};
         bin_in = bin_ff << 1;
         cnt_in = is_last ? CNT_W'(NUM_DIGITS) : cnt_ff - CNT_W'(1);
      end

      if (skip || emit) begin
         bcd_in = bcd_ff << 4;
         cnt_in = cnt_ff - CNT_W'(1);
      end

      if (emit) begin
         started_in        = 1'b1;
         rsp_valid_in      = 1'b1;
         rsp_char_code_in  = ASCII_ZERO + {2'b00, top_digit};
         rsp_last_digit_in = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff            <= bin_in;
      bcd_ff            <= bcd_in;
      cnt_ff            <= cnt_in;
      started_ff        <= started_in;
      rsp_char_code_ff  <= rsp_char_code_in;
      rsp_last_digit_ff <= rsp_last_digit_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_code  = rsp_char_code_ff;
   assign rsp_last_digit = rsp_last_digit_ff;

endmodule

FILE: sv/binary_to_decimal_digits_unit.sv
// Converts an unsigned VALUE_BITS-bit number (given as two 64-bit halves, upper bits ignored)
// into its decimal ASCII digits, most significant first, no leading zeros, one digit per
// response; a zero value gives a single '0', and the final digit carries rsp_last_digit. A
// two-entry request queue sits in front of a bit-serial double-dabble converter, so up to two
// requests are taken while a conversion runs. Each nonzero request occupies the converter
// for one shift per input bit, then one step per decimal digit position (D = 39 at 128
// bits), leading zeros included; a step that gives a digit waits until the response slot
// is free. A zero request skips the shifts. The single shift-and-correct converter takes
// the next queued request only after the last digit of the current one is given out.
module binary_to_decimal_digits_unit #(
   parameter int VALUE_BITS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_value_high,
   input  logic [63:0] req_value_low,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_char_code,
   output logic        rsp_last_digit
);
   import b2d_pkg::*;

   logic                  q_valid;
   logic                  q_pop;
   logic [VALUE_BITS-1:0] q_value;
   logic                  q_zero;

   b2d_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value_high (req_value_high),
      .req_value_low  (req_value_low),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_value        (q_value),
      .q_zero         (q_zero)
   );

   b2d_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_value        (q_value),
      .q_zero         (q_zero),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_char_code  (rsp_char_code),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule
